[design/dpf_pkg.sv]
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared types, register codes and helpers for the depth pair fusion block.
// ----------------------------------------------------------------------------
package dpf_pkg;

	// Width of every depth, score and gradient value.
	localparam int unsigned DW = 8;

	// Configuration port geometry.
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 8;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONF_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SINGLE_GOOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAIR_GOOD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OVERLAP     = 3'd5;

	// Fusion rules selected by the mode register.
	typedef enum logic [2:0] {
		MODE_GATED   = 3'd0,
		MODE_MIN     = 3'd1,
		MODE_MIN_NZ  = 3'd2,
		MODE_BETTER  = 3'd3,
		MODE_SECOND  = 3'd4,
		MODE_AVG     = 3'd5,
		MODE_OVERLAP = 3'd6,
		MODE_INVERT  = 3'd7
	} mode_t;

	// Register values after reset.
	localparam logic [DW-1:0] RST_CONF_LIMIT  = 8'd100;
	localparam logic [DW-1:0] RST_NEAR_LIMIT  = 8'd230;
	localparam logic [DW-1:0] RST_SINGLE_GOOD = 8'd50;
	localparam logic [DW-1:0] RST_PAIR_GOOD   = 8'd100;
	localparam logic [DW-1:0] RST_OVERLAP     = 8'd20;

	// Markers of the overlap rule.
	localparam logic [DW-1:0] MARK_FIRST_BETTER  = 8'd150;
	localparam logic [DW-1:0] MARK_SECOND_BETTER = 8'd255;

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		mode_t         mode;
		logic [DW-1:0] confidence_limit;
		logic [DW-1:0] near_limit;
		logic [DW-1:0] single_good_limit;
		logic [DW-1:0] pair_good_limit;
		logic [DW-1:0] overlap_limit;
	} cfg_t;

	// Compare results produced by the first stage.
	typedef struct packed {
		logic a_better;      // score_a < score_b
		logic b_better;      // score_b < score_a
		logic sa_lt_conf;    // score_a < confidence_limit
		logic sb_lt_conf;    // score_b < confidence_limit
		logic a_far;         // depth_a < near_limit
		logic b_far;         // depth_b < near_limit
		logic ratio_ok;      // 4*b < 5*a and 4*a < 5*b
		logic avg_score_ok;  // both 4*score < 5*confidence_limit
		logic a_le_b;        // depth_a <= depth_b
		logic any_zero;      // one of the depths is zero
		logic sb_lt_single;  // score_b < single_good_limit
		logic pair_ok;       // both scores < pair_good_limit
		logic sa_lt_ovl;     // score_a < overlap_limit
		logic sb_lt_ovl;     // score_b < overlap_limit
	} flags_t;

	// Candidate depth of every rule, produced by the second stage.
	typedef struct packed {
		logic [DW-1:0] gated;
		logic [DW-1:0] min_d;
		logic [DW-1:0] min_nz;
		logic [DW-1:0] better;
		logic [DW-1:0] second;
		logic [DW-1:0] avg;
		logic [DW-1:0] overlap;
		logic [DW-1:0] invert;
	} cand_t;

	// Scaled copies used by the exact ratio test.
	function automatic logic [DW+2:0] times4(input logic [DW-1:0] x);
		return {1'b0, x, 2'b00};
	endfunction

	function automatic logic [DW+2:0] times5(input logic [DW-1:0] x);
		return {1'b0, x, 2'b00} + {3'b000, x};
	endfunction

endpackage

[design/dpf_cfg.sv]
// ----------------------------------------------------------------------------
// dpf_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dpf_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dpf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dpf_pkg::CFG_DATA_W-1:0]      cfg_data,
	output dpf_pkg::cfg_t                       cfg
);

	dpf_pkg::mode_t                mode_q;
	logic [dpf_pkg::DW-1:0]        confidence_limit_q;
	logic [dpf_pkg::DW-1:0]        near_limit_q;
	logic [dpf_pkg::DW-1:0]        single_good_limit_q;
	logic [dpf_pkg::DW-1:0]        pair_good_limit_q;
	logic [dpf_pkg::DW-1:0]        overlap_limit_q;

	// Register writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q              <= dpf_pkg::MODE_GATED;
			confidence_limit_q  <= dpf_pkg::RST_CONF_LIMIT;
			near_limit_q        <= dpf_pkg::RST_NEAR_LIMIT;
			single_good_limit_q <= dpf_pkg::RST_SINGLE_GOOD;
			pair_good_limit_q   <= dpf_pkg::RST_PAIR_GOOD;
			overlap_limit_q     <= dpf_pkg::RST_OVERLAP;
		end else if (cfg_we) begin
			case (cfg_index)
				dpf_pkg::REG_MODE:        mode_q <= dpf_pkg::mode_t'(cfg_data[2:0]);
				dpf_pkg::REG_CONF_LIMIT:  confidence_limit_q  <= cfg_data[dpf_pkg::DW-1:0];
				dpf_pkg::REG_NEAR_LIMIT:  near_limit_q        <= cfg_data[dpf_pkg::DW-1:0];
				dpf_pkg::REG_SINGLE_GOOD: single_good_limit_q <= cfg_data[dpf_pkg::DW-1:0];
				dpf_pkg::REG_PAIR_GOOD:   pair_good_limit_q   <= cfg_data[dpf_pkg::DW-1:0];
				dpf_pkg::REG_OVERLAP:     overlap_limit_q     <= cfg_data[dpf_pkg::DW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg.mode              = mode_q;
	assign cfg.confidence_limit  = confidence_limit_q;
	assign cfg.near_limit        = near_limit_q;
	assign cfg.single_good_limit = single_good_limit_q;
	assign cfg.pair_good_limit   = pair_good_limit_q;
	assign cfg.overlap_limit     = overlap_limit_q;

endmodule

[design/dpf_cmp.sv]
// ----------------------------------------------------------------------------
// dpf_cmp
// First pipeline stage: all score, depth and ratio compares of one pixel.
// ----------------------------------------------------------------------------
module dpf_cmp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dpf_pkg::cfg_t            cfg,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [dpf_pkg::DW-1:0]   depth_a,
	input  logic [dpf_pkg::DW-1:0]   depth_b,
	input  logic [dpf_pkg::DW-1:0]   score_a,
	input  logic [dpf_pkg::DW-1:0]   score_b,
	input  logic [dpf_pkg::DW-1:0]   grad_a,
	input  logic [dpf_pkg::DW-1:0]   grad_b,
	output logic                     valid_s1,
	input  logic                     out_ready,
	output logic [dpf_pkg::DW-1:0]   depth_a_s1,
	output logic [dpf_pkg::DW-1:0]   depth_b_s1,
	output logic [dpf_pkg::DW-1:0]   score_a_s1,
	output logic [dpf_pkg::DW:0]     sum_s1,
	output dpf_pkg::flags_t          flags_s1,
	output logic [dpf_pkg::DW-1:0]   conf_s1
);

	dpf_pkg::flags_t          flags_d;
	logic [dpf_pkg::DW+2:0]   conf5;

	assign in_ready = !valid_s1 || out_ready;
	assign conf5    = dpf_pkg::times5(cfg.confidence_limit);

	// Compares against each other and against the limit registers.
	always_comb begin
		flags_d.a_better     = score_a < score_b;
		flags_d.b_better     = score_b < score_a;
		flags_d.sa_lt_conf   = score_a < cfg.confidence_limit;
		flags_d.sb_lt_conf   = score_b < cfg.confidence_limit;
		flags_d.a_far        = depth_a < cfg.near_limit;
		flags_d.b_far        = depth_b < cfg.near_limit;
		flags_d.ratio_ok     = (dpf_pkg::times4(depth_b) < dpf_pkg::times5(depth_a)) &&
		                       (dpf_pkg::times4(depth_a) < dpf_pkg::times5(depth_b));
		flags_d.avg_score_ok = (dpf_pkg::times4(score_a) < conf5) &&
		                       (dpf_pkg::times4(score_b) < conf5);
		flags_d.a_le_b       = depth_a <= depth_b;
		flags_d.any_zero     = (depth_a == '0) || (depth_b == '0);
		flags_d.sb_lt_single = score_b < cfg.single_good_limit;
		flags_d.pair_ok      = (score_a < cfg.pair_good_limit) &&
		                       (score_b < cfg.pair_good_limit);
		flags_d.sa_lt_ovl    = score_a < cfg.overlap_limit;
		flags_d.sb_lt_ovl    = score_b < cfg.overlap_limit;
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			depth_a_s1 <= depth_a;
			depth_b_s1 <= depth_b;
			score_a_s1 <= score_a;
			sum_s1     <= {1'b0, depth_a} + {1'b0, depth_b};
			flags_s1   <= flags_d;
			conf_s1    <= (grad_a < grad_b) ? grad_a : grad_b;
		end
	end

	// A passing ratio test needs two nonzero depths.
	a_ratio_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && flags_s1.ratio_ok |-> (depth_a_s1 != '0) && (depth_b_s1 != '0))
		else $error("ratio test passed with a zero depth");

endmodule

[design/dpf_cand.sv]
// ----------------------------------------------------------------------------
// dpf_cand
// Second pipeline stage: the candidate depth of every fusion rule.
// ----------------------------------------------------------------------------
module dpf_cand (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [dpf_pkg::DW-1:0]   depth_a_s1,
	input  logic [dpf_pkg::DW-1:0]   depth_b_s1,
	input  logic [dpf_pkg::DW-1:0]   score_a_s1,
	input  logic [dpf_pkg::DW:0]     sum_s1,
	input  dpf_pkg::flags_t          flags_s1,
	input  logic [dpf_pkg::DW-1:0]   conf_s1,
	output logic                     valid_s2,
	input  logic                     out_ready,
	output dpf_pkg::cand_t           cand_s2,
	output logic [dpf_pkg::DW-1:0]   conf_s2
);

	dpf_pkg::cand_t           cand_d;
	logic [dpf_pkg::DW-1:0]   avg;
	logic [dpf_pkg::DW-1:0]   max_d;

	assign in_ready = !valid_s2 || out_ready;
	assign avg      = sum_s1[dpf_pkg::DW:1];

	// One candidate per rule; the last stage picks among them.
	always_comb begin
		cand_d.min_d  = flags_s1.a_le_b ? depth_a_s1 : depth_b_s1;
		max_d         = flags_s1.a_le_b ? depth_b_s1 : depth_a_s1;
		cand_d.min_nz = flags_s1.any_zero ? max_d : cand_d.min_d;
		cand_d.better = flags_s1.a_better ? depth_a_s1 : depth_b_s1;
		cand_d.second = flags_s1.sb_lt_single ? depth_b_s1 : '0;
		cand_d.avg    = flags_s1.pair_ok ? avg : '0;
		cand_d.invert = ~score_a_s1;

		if (flags_s1.a_better && flags_s1.sa_lt_ovl) begin
			cand_d.overlap = dpf_pkg::MARK_FIRST_BETTER;
		end else if (flags_s1.b_better && flags_s1.sb_lt_ovl) begin
			cand_d.overlap = dpf_pkg::MARK_SECOND_BETTER;
		end else begin
			cand_d.overlap = '0;
		end

		// Gated choice: the clearly better map, else the agreeing average.
		if (flags_s1.a_better && flags_s1.sa_lt_conf && flags_s1.a_far) begin
			cand_d.gated = depth_a_s1;
		end else if (flags_s1.b_better && flags_s1.sb_lt_conf && flags_s1.b_far) begin
			cand_d.gated = depth_b_s1;
		end else if (flags_s1.ratio_ok && flags_s1.avg_score_ok) begin
			cand_d.gated = avg;
		end else begin
			cand_d.gated = '0;
		end
	end

	// Stage valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cand_s2 <= cand_d;
			conf_s2 <= conf_s1;
		end
	end

	// Replacing a zero depth by the other one can only raise the minimum.
	a_min_nz_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> cand_s2.min_d <= cand_s2.min_nz)
		else $error("minimum unless black fell below plain minimum");

endmodule

[design/dpf_pick.sv]
// ----------------------------------------------------------------------------
// dpf_pick
// Third pipeline stage: rule selection by mode and the output register.
// ----------------------------------------------------------------------------
module dpf_pick (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dpf_pkg::mode_t           mode,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  dpf_pkg::cand_t           cand_s2,
	input  logic [dpf_pkg::DW-1:0]   conf_s2,
	output logic                     valid_s3,
	input  logic                     out_ready,
	output logic [dpf_pkg::DW-1:0]   fused_s3,
	output logic [dpf_pkg::DW-1:0]   conf_s3
);

	logic [dpf_pkg::DW-1:0] fused_d;

	assign in_ready = !valid_s3 || out_ready;

	// Select the candidate of the active rule.
	always_comb begin
		case (mode)
			dpf_pkg::MODE_GATED:   fused_d = cand_s2.gated;
			dpf_pkg::MODE_MIN:     fused_d = cand_s2.min_d;
			dpf_pkg::MODE_MIN_NZ:  fused_d = cand_s2.min_nz;
			dpf_pkg::MODE_BETTER:  fused_d = cand_s2.better;
			dpf_pkg::MODE_SECOND:  fused_d = cand_s2.second;
			dpf_pkg::MODE_AVG:     fused_d = cand_s2.avg;
			dpf_pkg::MODE_OVERLAP: fused_d = cand_s2.overlap;
			dpf_pkg::MODE_INVERT:  fused_d = cand_s2.invert;
			default:               fused_d = cand_s2.gated;
		endcase
	end

	// Output valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			fused_s3 <= fused_d;
			conf_s3  <= conf_s2;
		end
	end

	// The overlap rule only ever emits one of its two markers or zero.
	a_overlap_codes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && (mode == dpf_pkg::MODE_OVERLAP) |->
			(fused_s3 == '0) || (fused_s3 == dpf_pkg::MARK_FIRST_BETTER) ||
			(fused_s3 == dpf_pkg::MARK_SECOND_BETTER))
		else $error("overlap rule produced an unknown marker");

endmodule

[design/depth_pair_fusion_pixel.sv]
// ----------------------------------------------------------------------------
// depth_pair_fusion_pixel
// Per-pixel fusion of two depth maps with scores and gradient confidence.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item on the s_ channel is one pixel carrying the depth, the
//   matching score and the gradient confidence of both maps. Each output item
//   on the m_ channel is the fused depth and the combined confidence (the
//   smaller gradient value). Items leave in the order they arrive, one result
//   per input item.
//   The block is a three-stage pipeline: compares, per-rule candidates, then
//   rule selection into the output register. Each accepted item passes the
//   stage-one and stage-two registers before m_tvalid rises for it.
//   The block takes one item per cycle as long as the receiver keeps up.
//   When the receiver stalls, the output item holds and the stages in front
//   keep filling until every stage is full; only then does s_tready drop.
//   No item is lost or repeated.
//   The configuration registers are written through cfg_we, cfg_index and
//   cfg_data and should only change while the pipeline is empty.
//   Reset clears all valid bits and loads the register defaults: gated rule,
//   confidence limit 100, near limit 230, single limit 50, pair limit 100 and
//   overlap limit 20.
// ----------------------------------------------------------------------------
module depth_pair_fusion_pixel (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [dpf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dpf_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Input pixel stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [6*dpf_pkg::DW-1:0] s_tdata,  // depth_a, depth_b, score_a, score_b, grad_a, grad_b
	// Output pixel stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [2*dpf_pkg::DW-1:0]            m_tdata   // fused_depth, min_grad
);

	localparam int unsigned DW = dpf_pkg::DW;

	dpf_pkg::cfg_t       cfg;

	logic                valid_s1;
	logic                ready_s2;
	logic [DW-1:0]       depth_a_s1;
	logic [DW-1:0]       depth_b_s1;
	logic [DW-1:0]       score_a_s1;
	logic [DW:0]         sum_s1;
	dpf_pkg::flags_t     flags_s1;
	logic [DW-1:0]       conf_s1;

	logic                valid_s2;
	logic                ready_s3;
	dpf_pkg::cand_t      cand_s2;
	logic [DW-1:0]       conf_s2;

	logic [DW-1:0]       fused_s3;
	logic [DW-1:0]       conf_s3;

	// Configuration registers.
	dpf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage one: compares.
	dpf_cmp u_cmp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.depth_a    (s_tdata[DW-1:0]),
		.depth_b    (s_tdata[2*DW-1:DW]),
		.score_a    (s_tdata[3*DW-1:2*DW]),
		.score_b    (s_tdata[4*DW-1:3*DW]),
		.grad_a     (s_tdata[5*DW-1:4*DW]),
		.grad_b     (s_tdata[6*DW-1:5*DW]),
		.valid_s1   (valid_s1),
		.out_ready  (ready_s2),
		.depth_a_s1 (depth_a_s1),
		.depth_b_s1 (depth_b_s1),
		.score_a_s1 (score_a_s1),
		.sum_s1     (sum_s1),
		.flags_s1   (flags_s1),
		.conf_s1    (conf_s1)
	);

	// Stage two: candidates of every rule.
	dpf_cand u_cand (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_s1),
		.in_ready   (ready_s2),
		.depth_a_s1 (depth_a_s1),
		.depth_b_s1 (depth_b_s1),
		.score_a_s1 (score_a_s1),
		.sum_s1     (sum_s1),
		.flags_s1   (flags_s1),
		.conf_s1    (conf_s1),
		.valid_s2   (valid_s2),
		.out_ready  (ready_s3),
		.cand_s2    (cand_s2),
		.conf_s2    (conf_s2)
	);

	// Stage three: rule selection and output register.
	dpf_pick u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (cfg.mode),
		.in_valid  (valid_s2),
		.in_ready  (ready_s3),
		.cand_s2   (cand_s2),
		.conf_s2   (conf_s2),
		.valid_s3  (m_tvalid),
		.out_ready (m_tready),
		.fused_s3  (fused_s3),
		.conf_s3   (conf_s3)
	);

	assign m_tdata = {conf_s3, fused_s3};

	// With the output stage empty, nothing in front can be blocked.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while the output stage is empty");

endmodule

[tb/sv/depth_pair_fusion_pixel_test.sv]
// ----------------------------------------------------------------------------
// depth_pair_fusion_pixel_test
// Self-checking testbench for the depth pair fusion pixel block. A queue of
// pixels feeds a clocked driver with random gaps. A clocked monitor stalls
// the output at random, checks every fused item against a predicted copy,
// and the run steps through every fusion rule and several register settings.
// ----------------------------------------------------------------------------
module depth_pair_fusion_pixel_test;

	// Pipeline depth of the block, used for the quiet time before writes.
	localparam int PIPE_DEPTH   = 3;
	// Length of the long output hold-off that backs up the pipeline.
	localparam int HOLD_CYCLES  = 80;
	// Pixels per random phase, and number of phases.
	localparam int PHASE_PIXELS = 42;
	localparam int PHASES       = 17;

	// One input pixel, laid out as on s_tdata (depth_a in the lowest bits).
	typedef struct packed {
		logic [dpf_pkg::DW-1:0] grad_b;
		logic [dpf_pkg::DW-1:0] grad_a;
		logic [dpf_pkg::DW-1:0] score_b;
		logic [dpf_pkg::DW-1:0] score_a;
		logic [dpf_pkg::DW-1:0] depth_b;
		logic [dpf_pkg::DW-1:0] depth_a;
	} pixel_t;

	// One output item, laid out as on m_tdata (fused_depth in the lowest bits).
	typedef struct packed {
		logic [dpf_pkg::DW-1:0] min_grad;
		logic [dpf_pkg::DW-1:0] fused_depth;
	} fused_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [dpf_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dpf_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [6*dpf_pkg::DW-1:0]       s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [2*dpf_pkg::DW-1:0]       m_tdata;

	// Pixels waiting to be sent and fused items waiting to come out.
	pixel_t pending_pixels[$];
	fused_t fused_expect[$];

	// Register values the prediction uses; they change only while idle.
	dpf_pkg::cfg_t fuse_cfg;

	int  mismatches = 0;
	int  send_gap   = 0;
	int  send_calm  = 0;
	int  recv_stall = 0;
	int  recv_calm  = 0;
	bit  squeeze_go = 1'b0;
	logic hold_off;

	depth_pair_fusion_pixel uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Predicted fused depth and combined confidence of one pixel.
	function automatic fused_t fuse_pixel(pixel_t p, dpf_pkg::cfg_t c);
		fused_t f;
		int unsigned a, b, sa, sb, t, nl, sg, pg, ol;
		a  = 32'(p.depth_a);
		b  = 32'(p.depth_b);
		sa = 32'(p.score_a);
		sb = 32'(p.score_b);
		t  = 32'(c.confidence_limit);
		nl = 32'(c.near_limit);
		sg = 32'(c.single_good_limit);
		pg = 32'(c.pair_good_limit);
		ol = 32'(c.overlap_limit);
		f.min_grad = (p.grad_a < p.grad_b) ? p.grad_a : p.grad_b;
		f.fused_depth = '0;
		case (c.mode)
			dpf_pkg::MODE_GATED: begin
				// Best score wins unless too close; else average if the depths agree.
				if (sa < sb && sa < t && a < nl)
					f.fused_depth = p.depth_a;
				else if (sb < sa && sb < t && b < nl)
					f.fused_depth = p.depth_b;
				else if (4 * b < 5 * a && 4 * a < 5 * b && 4 * sa < 5 * t && 4 * sb < 5 * t)
					f.fused_depth = 8'((a + b) >> 1);
			end
			dpf_pkg::MODE_MIN: f.fused_depth = (a < b) ? p.depth_a : p.depth_b;
			dpf_pkg::MODE_MIN_NZ: begin
				if (a == 0 || b == 0)
					f.fused_depth = (a > b) ? p.depth_a : p.depth_b;
				else
					f.fused_depth = (a < b) ? p.depth_a : p.depth_b;
			end
			dpf_pkg::MODE_BETTER: f.fused_depth = (sa < sb) ? p.depth_a : p.depth_b;
			dpf_pkg::MODE_SECOND: begin
				if (sb < sg)
					f.fused_depth = p.depth_b;
			end
			dpf_pkg::MODE_AVG: begin
				if (sa < pg && sb < pg)
					f.fused_depth = 8'((a + b) >> 1);
			end
			dpf_pkg::MODE_OVERLAP: begin
				if (sa < sb && sa < ol)
					f.fused_depth = dpf_pkg::MARK_FIRST_BETTER;
				else if (sb < sa && sb < ol)
					f.fused_depth = dpf_pkg::MARK_SECOND_BETTER;
			end
			dpf_pkg::MODE_INVERT: f.fused_depth = 8'hFF - p.score_a;
			default: f.fused_depth = '0;
		endcase
		return f;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// A value spread around a center, clipped to the 8-bit range.
	function automatic logic [dpf_pkg::DW-1:0] near_value(int center, int spread);
		int v;
		v = center + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return 8'(v);
	endfunction

	// Random pixel aimed at the thresholds of the current rule.
	function automatic pixel_t random_pixel(dpf_pkg::cfg_t c);
		pixel_t p;
		int lim;
		case (c.mode)
			dpf_pkg::MODE_SECOND:  lim = int'(c.single_good_limit);
			dpf_pkg::MODE_AVG:     lim = int'(c.pair_good_limit);
			dpf_pkg::MODE_OVERLAP: lim = int'(c.overlap_limit);
			default:               lim = int'(c.confidence_limit);
		endcase
		p.depth_a = 8'($urandom_range(0, 255));
		p.depth_b = 8'($urandom_range(0, 255));
		p.score_a = 8'($urandom_range(0, 255));
		p.score_b = 8'($urandom_range(0, 255));
		p.grad_a  = 8'($urandom_range(0, 255));
		p.grad_b  = 8'($urandom_range(0, 255));
		// A tenth of the pixels stay fully random.
		if ($urandom_range(0, 9) == 0)
			return p;
		case ($urandom_range(0, 7))
			0:       p.depth_a = '0;
			1:       p.depth_a = 8'hFF;
			2, 3:    p.depth_a = near_value(int'(c.near_limit), 4);
			default: ;
		endcase
		// Keep the two depths close often enough to hit the ratio test edges.
		if ($urandom_range(0, 2) != 0)
			p.depth_b = near_value(int'(p.depth_a), int'(p.depth_a) / 4 + 2);
		else if ($urandom_range(0, 5) == 0)
			p.depth_b = '0;
		// Scores straddle both the limit and 1.25 times the limit.
		p.score_a = near_value(lim + lim / 8, lim / 2 + 6);
		if ($urandom_range(0, 7) == 0)
			p.score_b = p.score_a;
		else
			p.score_b = near_value(lim + lim / 8, lim / 2 + 6);
		return p;
	endfunction

	task automatic add_pixel(input int da, input int db, input int sa, input int sb,
			input int ga, input int gb);
		pixel_t p;
		p.depth_a = 8'(da);
		p.depth_b = 8'(db);
		p.score_a = 8'(sa);
		p.score_b = 8'(sb);
		p.grad_a  = 8'(ga);
		p.grad_b  = 8'(gb);
		pending_pixels.push_back(p);
	endtask

	// Wait until every pixel is sent and every fused item has come out.
	task automatic settle();
		while (pending_pixels.size() != 0 || s_tvalid || fused_expect.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	// One register write; the enable stays high until end_writes.
	task automatic set_reg(input logic [dpf_pkg::CFG_IDX_W-1:0] idx,
			input logic [dpf_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			dpf_pkg::REG_MODE:        fuse_cfg.mode = dpf_pkg::mode_t'(val[2:0]);
			dpf_pkg::REG_CONF_LIMIT:  fuse_cfg.confidence_limit = val;
			dpf_pkg::REG_NEAR_LIMIT:  fuse_cfg.near_limit = val;
			dpf_pkg::REG_SINGLE_GOOD: fuse_cfg.single_good_limit = val;
			dpf_pkg::REG_PAIR_GOOD:   fuse_cfg.pair_good_limit = val;
			dpf_pkg::REG_OVERLAP:     fuse_cfg.overlap_limit = val;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic switch_mode(input dpf_pkg::mode_t m);
		settle();
		set_reg(dpf_pkg::REG_MODE, 8'(m));
		end_writes();
	endtask

	// Driver: offers the oldest pending pixel, predicts it once accepted.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				fused_expect.push_back(fuse_pixel(pixel_t'(s_tdata), fuse_cfg));
				void'(pending_pixels.pop_front());
				if (send_calm > 0) begin
					send_calm--;
					send_gap = 0;
				end else begin
					send_gap = pick_gap();
					if ($urandom_range(0, 49) == 0)
						send_calm = $urandom_range(20, 60);
				end
			end
			// A pixel that is offered and not taken holds as it is.
			if (!(s_tvalid && !s_tready)) begin
				if (send_gap > 0 && !hold_off) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_pixels[0];
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each fused item and stalls the output at random.
	always @(posedge clk) begin
		fused_t want;
		fused_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (fused_expect.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected item: depth %0d confidence %0d",
							got.fused_depth, got.min_grad);
					mismatches++;
				end else begin
					want = fused_expect.pop_front();
					if (got.fused_depth !== want.fused_depth ||
							got.min_grad !== want.min_grad) begin
						if (mismatches < 10)
							$display("mismatch: depth exp %0d got %0d, confidence exp %0d got %0d",
								want.fused_depth, got.fused_depth,
								want.min_grad, got.min_grad);
						mismatches++;
					end
				end
			end
			if (hold_off) begin
				m_tready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (recv_calm > 0) begin
					recv_calm--;
				end else begin
					recv_stall = pick_gap();
					if ($urandom_range(0, 63) == 0)
						recv_calm = $urandom_range(20, 80);
				end
			end
		end
	end

	// Long output hold-off while the sender keeps offering pixels.
	initial begin
		hold_off = 1'b0;
		wait (squeeze_go);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// Stimulus: directed pixels per rule, then random phases.
	initial begin
		logic [dpf_pkg::DW-1:0] lims [5];
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		fuse_cfg  = '{mode: dpf_pkg::MODE_GATED,
			confidence_limit: dpf_pkg::RST_CONF_LIMIT,
			near_limit: dpf_pkg::RST_NEAR_LIMIT,
			single_good_limit: dpf_pkg::RST_SINGLE_GOOD,
			pair_good_limit: dpf_pkg::RST_PAIR_GOOD,
			overlap_limit: dpf_pkg::RST_OVERLAP};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Gated rule at the reset limits.
		add_pixel(50, 60, 10, 20, 0, 255);       // first map better
		add_pixel(240, 60, 10, 20, 255, 0);      // better map too close, depths disagree
		add_pixel(50, 60, 30, 20, 7, 9);         // second map better
		add_pixel(100, 110, 60, 60, 200, 100);   // equal scores, average
		add_pixel(0, 110, 60, 60, 1, 1);         // zero depth fails the ratio test
		add_pixel(4, 5, 110, 110, 3, 2);         // ratio exactly 1.25 fails
		add_pixel(5, 6, 124, 124, 9, 9);         // just inside both averaging bounds
		add_pixel(5, 6, 125, 125, 9, 9);         // score at 1.25 times the limit
		add_pixel(230, 228, 99, 100, 128, 127);  // depth at near limit, falls to average
		add_pixel(255, 255, 255, 255, 255, 255);
		add_pixel(0, 0, 0, 0, 0, 0);

		switch_mode(dpf_pkg::MODE_MIN);
		add_pixel(0, 255, 0, 255, 0, 255);
		add_pixel(200, 100, 5, 5, 5, 5);
		switch_mode(dpf_pkg::MODE_MIN_NZ);
		add_pixel(0, 77, 1, 2, 3, 4);
		add_pixel(88, 0, 1, 2, 3, 4);
		add_pixel(30, 40, 1, 2, 3, 4);
		switch_mode(dpf_pkg::MODE_BETTER);
		add_pixel(10, 20, 5, 5, 6, 6);           // equal scores pick the second map
		add_pixel(10, 20, 4, 5, 6, 6);
		switch_mode(dpf_pkg::MODE_SECOND);
		add_pixel(10, 20, 0, 49, 1, 1);
		add_pixel(10, 20, 0, 50, 1, 1);
		switch_mode(dpf_pkg::MODE_AVG);
		add_pixel(255, 255, 99, 99, 2, 2);
		add_pixel(1, 2, 99, 100, 2, 2);
		switch_mode(dpf_pkg::MODE_OVERLAP);
		add_pixel(1, 1, 5, 10, 0, 0);
		add_pixel(1, 1, 10, 5, 0, 0);
		add_pixel(1, 1, 7, 7, 0, 0);             // equal scores give no marker
		switch_mode(dpf_pkg::MODE_INVERT);
		add_pixel(1, 1, 0, 3, 0, 0);
		add_pixel(1, 1, 255, 3, 0, 0);

		// Random phases, every rule at least twice, with all-zero and all-full limits.
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			for (int k = 0; k < 5; k++) begin
				if (ph == 8)
					lims[k] = '0;
				else if (ph == 14 || ph == 16)
					lims[k] = 8'hFF;
				else if (ph > 8)
					case ($urandom_range(0, 2))
						0:       lims[k] = '0;
						1:       lims[k] = 8'hFF;
						default: lims[k] = 8'($urandom_range(0, 255));
					endcase
				else
					lims[k] = 8'($urandom_range(0, 255));
			end
			set_reg(dpf_pkg::REG_MODE, 8'(ph % 8));
			set_reg(dpf_pkg::REG_CONF_LIMIT, lims[0]);
			set_reg(dpf_pkg::REG_NEAR_LIMIT, lims[1]);
			set_reg(dpf_pkg::REG_SINGLE_GOOD, lims[2]);
			set_reg(dpf_pkg::REG_PAIR_GOOD, lims[3]);
			set_reg(dpf_pkg::REG_OVERLAP, lims[4]);
			end_writes();
			for (int k = 0; k < PHASE_PIXELS; k++)
				pending_pixels.push_back(random_pixel(fuse_cfg));
			if (ph == 4)
				squeeze_go = 1'b1;
		end

		settle();
		if (mismatches == 0 && fused_expect.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule
